[rtl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants for the k-way merge core
// Field widths, result codes, command and result records, tree node type.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // field widths
  localparam int KEY_W = 32;
  localparam int IDX_W = 4;
  localparam int CFG_W = 5;

  // run index field spans 16 runs
  localparam int INDEX_SPAN = 16;

  // parameter defaults
  localparam int DEFAULT_MAX_RUNS = 16;
  localparam int QUEUE_DEPTH      = 2;

  // active_runs after reset
  localparam logic [CFG_W-1:0] ACTIVE_RUNS_RESET = 5'd2;

  // result kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // input op codes
  localparam logic OP_KEY = 1'b0;
  localparam logic OP_END = 1'b1;

  // classified command from the front end
  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_END,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [IDX_W-1:0]   src;
  } result_t;

  // node of the min-select tree
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [IDX_W-1:0]   idx;
  } node_t;

endpackage

[rtl/kwm_queue.sv]
// ----------------------------------------------------------------------------
// kwm_queue: small flip-flop FIFO
// Generic width and depth; head entry is shown while valid is high.
// ----------------------------------------------------------------------------
module kwm_queue
  import kwm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/kwm_front.sv]
// ----------------------------------------------------------------------------
// kwm_front: input side of the merge core
// Takes items, classifies them against the active run count, buffers them.
// ----------------------------------------------------------------------------
module kwm_front
  import kwm_pkg::*;
#(
  parameter int MAX_RUNS = DEFAULT_MAX_RUNS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [$clog2(((MAX_RUNS < INDEX_SPAN) ? MAX_RUNS : INDEX_SPAN) + 1)-1:0]
                              run_count,
  input  logic                push,
  output logic                full,
  input  logic                op,
  input  logic [IDX_W-1:0]    run_index,
  input  logic [KEY_W-1:0]    key,
  output logic                cmd_valid,
  input  logic                cmd_pop,
  output cmd_t                cmd_data
);

  localparam int LIM = (MAX_RUNS < INDEX_SPAN) ? MAX_RUNS : INDEX_SPAN;
  localparam int NW  = $clog2(LIM + 1);

  cmd_t                    cmd_in;
  logic [$bits(cmd_t)-1:0] q_out;
  logic                    in_range;

  // runs outside the active range turn into no-ops
  assign in_range = ({{(NW > IDX_W ? NW - IDX_W : 0){1'b0}}, run_index} < run_count);

  always_comb begin
    cmd_in.idx = run_index;
    cmd_in.key = key;
    if (!in_range) begin
      cmd_in.kind = CMD_NOP;
    end else if (op == OP_END) begin
      cmd_in.kind = CMD_END;
    end else begin
      cmd_in.kind = CMD_KEY;
    end
  end

  // command queue toward the merge engine
  kwm_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd_in),
    .full      (full),
    .pop       (cmd_pop),
    .valid     (cmd_valid),
    .pop_data  (q_out)
  );

  assign cmd_data = cmd_t'(q_out);

endmodule

[rtl/kwm_back.sv]
// ----------------------------------------------------------------------------
// kwm_back: merge engine
// Holds run heads, picks the smallest through a registered tree, emits results.
// ----------------------------------------------------------------------------
module kwm_back
  import kwm_pkg::*;
#(
  parameter int MAX_RUNS = DEFAULT_MAX_RUNS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [$clog2(((MAX_RUNS < INDEX_SPAN) ? MAX_RUNS : INDEX_SPAN) + 1)-1:0]
                              run_count,
  input  logic                cmd_valid,
  input  cmd_t                cmd_data,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output result_t             res_data
);

  localparam int LIM  = (MAX_RUNS < INDEX_SPAN) ? MAX_RUNS : INDEX_SPAN;
  localparam int NW   = $clog2(LIM + 1);
  localparam int IDXW = $clog2(LIM);
  localparam int TREE = 2 ** IDXW;
  localparam int CW   = (IDXW > 1) ? $clog2(IDXW) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [KEY_W-1:0]  head_keys [LIM];
  logic [LIM-1:0]    head_present;
  logic [LIM-1:0]    run_ended;
  logic [LIM-1:0]    wait_vec;
  logic              waiting;
  logic [IDXW-1:0]   cmd_slot;

  node_t             leaf   [TREE];
  node_t             nodes  [1:2*TREE-1];
  node_t             tree_q [1:TREE-1];
  node_t             root;

  // smaller key wins, lower run on a tie
  function automatic node_t pick(input node_t a, input node_t b);
    node_t r;
    if (a.valid && (!b.valid || (a.key <= b.key))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

  // leaves and waiting flags, one per run slot
  for (genvar g = 0; g < TREE; g++) begin : g_leaf
    if (g < LIM) begin : g_used
      assign leaf[g] = '{valid: head_present[g] && (NW'(g) < run_count),
                         key:   head_keys[g],
                         idx:   IDX_W'(g)};
      assign wait_vec[g] = (NW'(g) < run_count) && !head_present[g] && !run_ended[g];
    end else begin : g_pad
      assign leaf[g] = '{valid: 1'b0, key: '0, idx: '0};
    end
  end

  assign waiting  = |wait_vec;
  assign cmd_slot = cmd_data.idx[IDXW-1:0];

  // heap-ordered view: registered inner nodes, leaves at the bottom
  always_comb begin
    for (int j = 1; j < TREE; j++) begin
      nodes[j] = tree_q[j];
    end
    for (int i = 0; i < TREE; i++) begin
      nodes[TREE + i] = leaf[i];
    end
  end

  assign root = nodes[1];

  // one tree level settles per cycle
  always_ff @(posedge clk) begin
    for (int j = 1; j < TREE; j++) begin
      tree_q[j] <= pick(nodes[2*j], nodes[2*j+1]);
    end
  end

  // handshakes toward the queues
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign res_push = (state == ST_EMIT) && !waiting && !res_full;

  always_comb begin
    if (root.valid) begin
      res_data = '{kind: KIND_KEY, key: root.key, src: root.idx};
    end else begin
      res_data = '{kind: KIND_DONE, key: '0, src: '0};
    end
  end

  // head keys need no reset
  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd_data.kind == CMD_KEY) && !run_ended[cmd_slot]) begin
      head_keys[cmd_slot] <= cmd_data.key;
    end
  end

  // sequencer: update, tree scan, emission test
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      head_present <= '0;
      run_ended    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cnt   <= '0;
            state <= ST_SCAN;
            unique case (cmd_data.kind)
              CMD_KEY: begin
                if (!run_ended[cmd_slot]) begin
                  head_present[cmd_slot] <= 1'b1;
                end
              end
              CMD_END: run_ended[cmd_slot] <= 1'b1;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (cnt == CW'(IDXW - 1)) begin
            state <= ST_EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_EMIT: begin
          if (waiting) begin
            state <= ST_IDLE;
          end else if (!res_full) begin
            state <= ST_IDLE;
            if (root.valid) begin
              head_present[root.idx[IDXW-1:0]] <= 1'b0;
            end else begin
              // merge complete: start fresh
              head_present <= '0;
              run_ended    <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // run state holds still while the tree settles
  a_scan_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> ($stable(head_present) && $stable(run_ended)))
    else $error("run state changed during scan");

  // an emitted key comes from a held head
  a_key_from_head: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res_data.kind == KIND_KEY)) |-> head_present[res_data.src[IDXW-1:0]])
    else $error("emitted key from an empty run");

  // completion leaves a clean state
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res_data.kind == KIND_DONE)) |=> ((head_present == '0) && (run_ended == '0)))
    else $error("state not cleared after completion");

  // no command taken while an item is in flight
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state == ST_SCAN))
    else $error("command taken outside idle");

endmodule

[rtl/kway_sorted_run_merger_core.sv]
// ----------------------------------------------------------------------------
// kway_sorted_run_merger_core: k-way merge of ascending key runs
// An accepted item waits in the command queue until the engine, while idle,
// takes it and updates the run state. The engine then scans while the
// registered min-select tree settles and, in its emission state, pushes a
// result unless an active run still waits for a head; it holds while the
// result queue is full. It takes no new item before it is back in idle.
// Reset clears the run head and end flags and both queues, sets active_runs to 2.
// ----------------------------------------------------------------------------
module kway_sorted_run_merger_core
  import kwm_pkg::*;
#(
  parameter int MAX_RUNS = DEFAULT_MAX_RUNS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic [IDX_W-1:0]   run_index,
  input  logic [KEY_W-1:0]   key,
  output logic               empty,
  input  logic               pop,
  output logic               kind,
  output logic [KEY_W-1:0]   out_key,
  output logic [IDX_W-1:0]   source_run
);

  localparam int LIM = (MAX_RUNS < INDEX_SPAN) ? MAX_RUNS : INDEX_SPAN;
  localparam int NW  = $clog2(LIM + 1);

  logic [CFG_W-1:0]           active_runs;
  logic [NW-1:0]              run_count;
  logic                       cmd_valid;
  logic                       cmd_pop;
  cmd_t                       cmd_data;
  logic                       res_full;
  logic                       res_push;
  result_t                    res_data;
  logic                       res_valid;
  logic [$bits(result_t)-1:0] res_out;
  result_t                    res_head;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_runs <= ACTIVE_RUNS_RESET;
    end else if (cfg_we) begin
      active_runs <= cfg_wdata;
    end
  end

  // zero counts as one run, large values saturate
  always_comb begin
    if (active_runs == '0) begin
      run_count = NW'(1);
    end else if ({{(NW > CFG_W ? NW - CFG_W : 0){1'b0}}, active_runs} > (CFG_W > NW ?
                 CFG_W : NW)'(LIM)) begin
      run_count = NW'(LIM);
    end else begin
      run_count = active_runs[NW-1:0];
    end
  end

  kwm_front #(
    .MAX_RUNS (MAX_RUNS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .run_count (run_count),
    .push      (push),
    .full      (full),
    .op        (op),
    .run_index (run_index),
    .key       (key),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data)
  );

  kwm_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .run_count (run_count),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // result queue toward the consumer
  kwm_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (pop),
    .valid     (res_valid),
    .pop_data  (res_out)
  );

  assign res_head   = result_t'(res_out);
  assign empty      = !res_valid;
  assign kind       = res_head.kind;
  assign out_key    = res_head.key;
  assign source_run = res_head.src;

endmodule

[bench/kwm_merge_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kwm_merge_checker: scoreboard for the k-way merge core
// Watches the config port and both queue handshakes, keeps its own copy of
// the run heads, predicts each merged key or completion, and compares every
// popped result against the oldest prediction.
// ----------------------------------------------------------------------------
module kwm_merge_checker
  import kwm_pkg::*;
#(
  parameter int MAX_RUNS = DEFAULT_MAX_RUNS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               push,
  input  logic               full,
  input  logic               op,
  input  logic [IDX_W-1:0]   run_index,
  input  logic [KEY_W-1:0]   key,
  input  logic               empty,
  input  logic               pop,
  input  logic               kind,
  input  logic [KEY_W-1:0]   out_key,
  input  logic [IDX_W-1:0]   source_run,
  output int                 fail_count,
  output int                 pending_results
);

  // mirrored merge state
  logic [KEY_W-1:0] head_key [MAX_RUNS];
  bit               head_held [MAX_RUNS];
  bit               run_closed [MAX_RUNS];
  logic [CFG_W-1:0] runs_cfg;

  // merged results still to be popped, oldest first
  result_t merge_q [$];

  // number of runs taking part for a given register value
  function automatic int runs_in_play(logic [CFG_W-1:0] v);
    int lim;
    lim = (MAX_RUNS < INDEX_SPAN) ? MAX_RUNS : INDEX_SPAN;
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // apply one accepted item, queue the result it causes (if any)
  task automatic merge_item(logic o, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] k);
    int               n;
    int               i;
    int               best;
    bit               waiting;
    bit               found;
    logic [KEY_W-1:0] best_key;
    result_t          res;
    n        = runs_in_play(runs_cfg);
    waiting  = 1'b0;
    found    = 1'b0;
    best     = 0;
    best_key = '0;
    if (int'(idx) < n) begin
      if (o == OP_KEY) begin
        if (!run_closed[idx]) begin
          head_key[idx]  = k;
          head_held[idx] = 1'b1;
        end
      end else begin
        run_closed[idx] = 1'b1;
      end
    end
    // smallest head, lower run wins ties
    for (i = 0; i < n; i++) begin
      if (head_held[i]) begin
        if (!found || head_key[i] < best_key) begin
          best_key = head_key[i];
          best     = i;
        end
        found = 1'b1;
      end else if (!run_closed[i]) begin
        waiting = 1'b1;
      end
    end
    if (waiting) return;
    if (found) begin
      head_held[best] = 1'b0;
      res.kind = KIND_KEY;
      res.key  = best_key;
      res.src  = IDX_W'(best);
    end else begin
      // merge complete, start over
      for (i = 0; i < MAX_RUNS; i++) begin
        head_held[i]  = 1'b0;
        run_closed[i] = 1'b0;
      end
      res.kind = KIND_DONE;
      res.key  = '0;
      res.src  = '0;
    end
    merge_q.push_back(res);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_RUNS; i++) begin
        head_held[i]  = 1'b0;
        run_closed[i] = 1'b0;
        head_key[i]   = '0;
      end
      runs_cfg = ACTIVE_RUNS_RESET;
      merge_q.delete();
    end else begin
      // result side first: a result popped now came from an earlier item
      if (pop && !empty) begin
        if (merge_q.size() == 0) begin
          $error("unexpected result: kind=%0d out_key=%h source_run=%0d",
                 kind, out_key, source_run);
          fail_count++;
        end else begin
          want = merge_q.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            fail_count++;
          end
          if (out_key !== want.key) begin
            $error("out_key: expected %h, got %h", want.key, out_key);
            fail_count++;
          end
          if (source_run !== want.src) begin
            $error("source_run: expected %0d, got %0d", want.src, source_run);
            fail_count++;
          end
        end
      end
      if (cfg_we) runs_cfg = cfg_wdata;
      if (push && !full) merge_item(op, run_index, key);
    end
    pending_results = merge_q.size();
  end

endmodule

[bench/tb_kway_sorted_run_merger_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kway_sorted_run_merger_core: testbench for the k-way merge core
// Acts as the run producer: fills every active run, then refills the run
// named by each popped key until all runs end. Mixes in head replacement,
// end marks on held heads, ignored items and tied or unsorted keys, over
// several active_runs settings. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_kway_sorted_run_merger_core;
  import kwm_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int MAX_LEN      = 8;
  localparam int SETTLE       = 20;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             push      = 1'b0;
  logic             full;
  logic             op        = OP_KEY;
  logic [IDX_W-1:0] run_index = '0;
  logic [KEY_W-1:0] key       = '0;
  logic             empty;
  logic             pop       = 1'b0;
  logic             kind;
  logic [KEY_W-1:0] out_key;
  logic [IDX_W-1:0] source_run;

  int fail_count;
  int pending_results;

  // producer bookkeeping
  logic [KEY_W-1:0] run_keys [INDEX_SPAN][MAX_LEN];
  int               run_len [INDEX_SPAN];
  int               run_pos [INDEX_SPAN];
  bit               run_closed [INDEX_SPAN];
  result_t          popped [$];
  int               items_sent = 0;
  int               burst_left = 0;
  bit               driving    = 1'b0;

  always #5 clk = ~clk;

  kway_sorted_run_merger_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .full       (full),
    .op         (op),
    .run_index  (run_index),
    .key        (key),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .out_key    (out_key),
    .source_run (source_run)
  );

  kwm_merge_checker merge_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .push            (push),
    .full            (full),
    .op              (op),
    .run_index       (run_index),
    .key             (key),
    .empty           (empty),
    .pop             (pop),
    .kind            (kind),
    .out_key         (out_key),
    .source_run      (source_run),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // runs that take part for a register value
  function automatic int merge_width(int v);
    if (v == 0) return 1;
    if (v > INDEX_SPAN) return INDEX_SPAN;
    return v;
  endfunction

  // drop push before time passes with nothing to send
  task automatic release_bus();
    if (driving) begin
      push    <= 1'b0;
      driving = 1'b0;
    end
  endtask

  // offer one item, wait until taken; gaps between random bursts
  task automatic send_item(logic o, int idx, logic [KEY_W-1:0] k);
    if (burst_left == 0) begin
      release_bus();
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = chance(25) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    if (!driving) begin
      push    <= 1'b1;
      driving = 1'b1;
    end
    op        <= o;
    run_index <= IDX_W'(idx);
    key       <= k;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  task automatic next_result(output result_t r);
    if (popped.size() == 0) begin
      release_bus();
      while (popped.size() == 0) @(posedge clk);
    end
    r = popped.pop_front();
  endtask

  // register write once the core has drained
  task automatic write_active(int v);
    release_bus();
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // item the core ignores: index past the active runs
  task automatic send_outside(int n);
    send_item(1'($urandom_range(0, 1)), $urandom_range(n, INDEX_SPAN - 1), $urandom);
  endtask

  // harmless extra item; in-range only while some run is still open
  task automatic send_noise(int n);
    int  i;
    int  c;
    bit  any_open;
    c        = -1;
    any_open = 1'b0;
    for (i = 0; i < n; i++) begin
      if (run_closed[i] && (c < 0 || chance(50))) c = i;
      if (!run_closed[i]) any_open = 1'b1;
    end
    if (n < INDEX_SPAN && (chance(50) || c < 0 || !any_open)) begin
      send_outside(n);
    end else if (c >= 0 && any_open) begin
      if (chance(50)) send_item(OP_END, c, $urandom);
      else send_item(OP_KEY, c, $urandom);
    end
  endtask

  // random run contents: ties, extremes, spread and unsorted keys
  task automatic make_runs(int n);
    int               i;
    int               j;
    int               mode;
    int               step;
    logic [KEY_W-1:0] cur;
    logic [KEY_W:0]   sum;
    for (i = 0; i < n; i++) begin
      run_len[i] = chance(25) ? $urandom_range(0, MAX_LEN) : $urandom_range(0, 3);
      mode = $urandom_range(0, 4);
      case (mode)
        0: begin cur = $urandom_range(0, 3); step = 2; end
        1: begin cur = $urandom; step = 1000; end
        2: begin cur = 32'hFFFF_FFFF - $urandom_range(0, 8); step = 3; end
        default: begin cur = $urandom_range(0, 5000); step = 100000; end
      endcase
      for (j = 0; j < run_len[i]; j++) begin
        if (mode == 4) begin
          run_keys[i][j] = $urandom;
        end else begin
          run_keys[i][j] = cur;
          sum = {1'b0, cur} + $urandom_range(0, step);
          cur = sum[KEY_W] ? '1 : sum[KEY_W-1:0];
        end
      end
    end
  endtask

  // one full merge over n runs, reacting to each popped key
  task automatic run_merge(int n, int replace_pct, int hold_pct, int noise_pct);
    int      i;
    int      s;
    int      last;
    result_t r;
    last = n - 1;
    for (i = 0; i < INDEX_SPAN; i++) begin
      run_pos[i]    = 0;
      run_closed[i] = 1'b0;
    end
    // initial fill; nothing is emitted before the last run is served
    for (i = 0; i < n; i++) begin
      // a replaced head on an empty run stays held past its end mark
      if (i != last && (run_len[i] != 0 || n < INDEX_SPAN) && chance(replace_pct))
        send_item(OP_KEY, i, $urandom);
      if (run_len[i] == 0) begin
        send_item(OP_END, i, $urandom);
        run_closed[i] = 1'b1;
      end else begin
        send_item(OP_KEY, i, run_keys[i][0]);
        run_pos[i] = 1;
        // end mark behind a held head needs an outside index to kick
        if (i != last && n < INDEX_SPAN && run_len[i] == 1 && chance(hold_pct)) begin
          send_item(OP_END, i, $urandom);
          run_closed[i] = 1'b1;
        end
      end
    end
    // refill loop
    forever begin
      if (chance(noise_pct)) send_noise(n);
      next_result(r);
      if (r.kind == KIND_DONE) break;
      s = int'(r.src);
      if (run_closed[s]) begin
        // run already ended: just trigger the next selection
        send_outside(n);
      end else if (run_pos[s] < run_len[s]) begin
        send_item(OP_KEY, s, run_keys[s][run_pos[s]]);
        run_pos[s]++;
        if (run_pos[s] == run_len[s] && n < INDEX_SPAN && chance(hold_pct)) begin
          send_item(OP_END, s, $urandom);
          run_closed[s] = 1'b1;
        end
      end else begin
        send_item(OP_END, s, $urandom);
        run_closed[s] = 1'b1;
      end
    end
  endtask

  // result side: stall pattern changes every stretch
  initial begin : result_sink
    result_t got;
    bit      taken;
    int      mode;
    int      left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      taken    = pop && !empty;
      got.kind = kind;
      got.key  = out_key;
      got.src  = source_run;
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = (mode == 3) ? $urandom_range(1, 20) : $urandom_range(5, 60);
      end
      left--;
      case (mode)
        0:       pop <= 1'b1;
        1:       pop <= chance(50);
        2:       pop <= chance(25);
        default: pop <= 1'b0;
      endcase
      // hand over off the rising edge so the producer sees it cleanly
      if (taken) begin
        @(negedge clk);
        popped.push_back(got);
      end
    end
  end

  initial begin : stimulus
    int start;
    int phase;
    int v;
    int n;
    int rounds;
    int cfg_plan [5];
    cfg_plan = '{1, 16, 0, 31, 17};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset width, ties at both key extremes
    run_len[0] = 2; run_keys[0][0] = '0; run_keys[0][1] = '1;
    run_len[1] = 2; run_keys[1][0] = '0; run_keys[1][1] = '1;
    run_merge(2, 0, 0, 0);

    // directed: replaced heads, end on a held head, empty run, ignored items
    write_active(3);
    run_len[0] = 1; run_keys[0][0] = 32'd5;
    run_len[1] = 2; run_keys[1][0] = 32'd5; run_keys[1][1] = 32'd9;
    run_len[2] = 0;
    run_merge(3, 100, 100, 100);

    // random merges over a range of widths
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (phase < 5) v = cfg_plan[phase];
      else v = chance(60) ? $urandom_range(1, 4) : $urandom_range(0, 31);
      write_active(v);
      n = merge_width(v);
      rounds = $urandom_range(1, 3);
      repeat (rounds) begin
        make_runs(n);
        run_merge(n, 20, 25, 15);
      end
      phase++;
    end

    // drain and report
    release_bus();
    while (pending_results != 0) @(negedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[kway_sorted_run_merger_core] OK");
    end else begin
      $display("[kway_sorted_run_merger_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[kway_sorted_run_merger_core] ERROR");
    $finish;
  end

endmodule
